>>> rtl/tccs_pkg.sv
// ----------------------------------------------------------------------------
// tccs_pkg
// Shared constants and types for the text console with cursor and scroll.
// ----------------------------------------------------------------------------
package tccs_pkg;

	localparam int NUM_COLS_DEF = 80;
	localparam int NUM_ROWS_DEF = 30;

	localparam logic [7:0] SPACE_CODE   = 8'h20;
	localparam logic [7:0] NEWLINE_CODE = 8'h0A;

	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// sequencer commands to the datapath
	typedef struct packed {
		logic load_item;  // capture the accepted transaction
		logic calc_row;   // map logical row to physical row
		logic access;     // memory access and cursor update
		logic load_out;   // load the result register
	} cmd_t;

endpackage

>>> rtl/tccs_ram.sv
// ----------------------------------------------------------------------------
// tccs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tccs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/tccs_ctrl.sv
// ----------------------------------------------------------------------------
// tccs_ctrl
// Sequencer: accepts one transaction, steps it through the datapath and
// holds the result handshake.
// ----------------------------------------------------------------------------
module tccs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	output tccs_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_ROW  = 4'b0010,
		S_ACC  = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_vld_q;
	logic   out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_vld_q;
	assign out_free  = !out_vld_q || !out_stall;

	always_comb begin
		state_d       = state_q;
		cmd.load_item = 1'b0;
		cmd.calc_row  = 1'b0;
		cmd.access    = 1'b0;
		cmd.load_out  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_ROW;
				end
			end
			S_ROW: begin
				cmd.calc_row = 1'b1;
				state_d      = S_ACC;
			end
			S_ACC: begin
				cmd.access = 1'b1;
				state_d    = S_FIN;
			end
			S_FIN: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/tccs_dp.sv
// ----------------------------------------------------------------------------
// tccs_dp
// Datapath: cursor, circular row offset, per-row valid flags and fill
// counts, screen RAM and result register.
// ----------------------------------------------------------------------------
module tccs_dp #(
	parameter int NUM_COLS = tccs_pkg::NUM_COLS_DEF,
	parameter int NUM_ROWS = tccs_pkg::NUM_ROWS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  tccs_pkg::cmd_t cmd,
	input  logic [1:0]     op,
	input  logic [7:0]     char_code,
	input  logic [4:0]     read_row,
	input  logic [6:0]     read_col,
	output logic [7:0]     cell_data,
	output logic [6:0]     cursor_column,
	output logic [4:0]     cursor_line,
	output logic           scrolled
);

	localparam int COL_W  = $clog2(NUM_COLS);
	localparam int ROW_W  = $clog2(NUM_ROWS);
	localparam int FILL_W = $clog2(NUM_COLS + 1);
	localparam int CELLS  = NUM_COLS * NUM_ROWS;
	localparam int ADDR_W = $clog2(CELLS);

	// captured transaction
	logic [1:0] op_q;
	logic [7:0] code_q;
	logic [4:0] rrow_q;
	logic [6:0] rcol_q;

	// console state
	logic [COL_W-1:0]    cur_col_q;
	logic [ROW_W-1:0]    cur_row_q;
	logic [ROW_W-1:0]    top_q;
	logic [NUM_ROWS-1:0] row_vld_q;

	logic [ROW_W-1:0] phys_q;
	logic             in_range_q;
	logic             hit_vld_q;
	logic             scroll_q;

	logic             is_read;
	logic             in_range;
	logic [ROW_W:0]   lrow;
	logic [ROW_W:0]   row_sum;
	logic [ROW_W-1:0] phys_d;
	logic [ADDR_W-1:0] col_sel;
	logic [ADDR_W-1:0] addr;
	logic             put_char;
	logic [COL_W:0]   col_inc;
	logic [ROW_W:0]   row_inc;
	logic             wrap_col;
	logic [ROW_W-1:0] top_next;
	logic [FILL_W-1:0] fill_wdata;
	logic [FILL_W-1:0] fill_rdata;
	logic [7:0]       scr_rdata;
	logic [7:0]       cell_d;
	logic [31:0]      col_ext;
	logic [31:0]      row_ext;

	assign is_read  = (op_q == tccs_pkg::OP_READ);
	assign in_range = (32'(rrow_q) < 32'(NUM_ROWS)) && (32'(rcol_q) < 32'(NUM_COLS));
	assign put_char = (op_q == tccs_pkg::OP_PUT) && (code_q != tccs_pkg::NEWLINE_CODE);

	// logical to physical row through the circular top-row offset
	assign lrow    = (is_read && in_range) ? (ROW_W+1)'(rrow_q) : {1'b0, cur_row_q};
	assign row_sum = {1'b0, top_q} + lrow;
	assign phys_d  = (row_sum >= (ROW_W+1)'(NUM_ROWS)) ?
	                 ROW_W'(row_sum - (ROW_W+1)'(NUM_ROWS)) : row_sum[ROW_W-1:0];

	assign col_sel = is_read ? ADDR_W'(rcol_q) : ADDR_W'(cur_col_q);
	assign addr    = ADDR_W'(ADDR_W'(phys_q) * ADDR_W'(NUM_COLS)) + col_sel;

	assign col_inc    = (COL_W+1)'(cur_col_q) + 1'b1;
	assign wrap_col   = (col_inc >= (COL_W+1)'(NUM_COLS));
	assign top_next   = (top_q == ROW_W'(NUM_ROWS - 1)) ? '0 : top_q + 1'b1;
	assign fill_wdata = FILL_W'(col_inc);

	always_comb begin
		row_inc = (ROW_W+1)'(cur_row_q);
		if (op_q == tccs_pkg::OP_PUT && (code_q == tccs_pkg::NEWLINE_CODE || wrap_col)) begin
			row_inc = (ROW_W+1)'(cur_row_q) + 1'b1;
		end
	end

	tccs_ram #(
		.WIDTH (8),
		.DEPTH (CELLS)
	) u_screen (
		.clk   (clk),
		.we    (cmd.access && put_char),
		.waddr (addr),
		.wdata (code_q),
		.re    (cmd.access && is_read && in_range),
		.raddr (addr),
		.rdata (scr_rdata)
	);

	// columns written so far in each physical row; cells beyond read as space
	tccs_ram #(
		.WIDTH (FILL_W),
		.DEPTH (NUM_ROWS)
	) u_fill (
		.clk   (clk),
		.we    (cmd.access && put_char),
		.waddr (phys_q),
		.wdata (fill_wdata),
		.re    (cmd.access && is_read && in_range),
		.raddr (phys_q),
		.rdata (fill_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q   <= op;
			code_q <= char_code;
			rrow_q <= read_row;
			rcol_q <= read_col;
		end
		if (cmd.calc_row) begin
			phys_q <= phys_d;
		end
		if (cmd.access) begin
			in_range_q <= in_range;
			hit_vld_q  <= row_vld_q[phys_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q <= '0;
			cur_row_q <= '0;
			top_q     <= '0;
			row_vld_q <= '0;
			scroll_q  <= 1'b0;
		end else if (cmd.access) begin
			scroll_q <= 1'b0;
			unique case (op_q)
				tccs_pkg::OP_PUT: begin
					if (put_char) begin
						row_vld_q[phys_q] <= 1'b1;
						cur_col_q         <= wrap_col ? '0 : COL_W'(col_inc);
					end else begin
						cur_col_q <= '0;
					end
					if (row_inc >= (ROW_W+1)'(NUM_ROWS)) begin
						// old top row becomes the blank bottom row
						row_vld_q[top_q] <= 1'b0;
						top_q            <= top_next;
						cur_row_q        <= ROW_W'(NUM_ROWS - 1);
						scroll_q         <= 1'b1;
					end else begin
						cur_row_q <= ROW_W'(row_inc);
					end
				end
				tccs_pkg::OP_CLEAR: begin
					row_vld_q <= '0;
					cur_col_q <= '0;
					cur_row_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cell_d = 8'h00;
		if (is_read && in_range_q) begin
			if (hit_vld_q && (32'(rcol_q) < 32'(fill_rdata))) begin
				cell_d = scr_rdata;
			end else begin
				cell_d = tccs_pkg::SPACE_CODE;
			end
		end
	end

	assign col_ext = 32'(cur_col_q);
	assign row_ext = 32'(cur_row_q);

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			cell_data     <= cell_d;
			cursor_column <= col_ext[6:0];
			cursor_line   <= row_ext[4:0];
			scrolled      <= scroll_q;
		end
	end

endmodule

>>> rtl/text_console_cursor_scroll.sv
// A new transaction is taken only after the last one has left the four-step sequencer
// (accept, row mapping, memory access, result load); a stalled output holds it in the last step.
// Scroll is a rotation of the top-row offset plus one row flag, so it costs nothing extra.
// Reset: cursor home, row flags cleared at once so every cell reads as space;
// no clearing pass over the screen RAM.
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// Character-cell console: put, clear and read transactions with cursor,
// line wrap and scroll.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll #(
	parameter int NUM_COLS = tccs_pkg::NUM_COLS_DEF,
	parameter int NUM_ROWS = tccs_pkg::NUM_ROWS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] op,
	input  logic [7:0] char_code,
	input  logic [4:0] read_row,
	input  logic [6:0] read_col,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] cell_data,
	output logic [6:0] cursor_column,
	output logic [4:0] cursor_line,
	output logic       scrolled
);

	tccs_pkg::cmd_t cmd;

	tccs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	tccs_dp #(
		.NUM_COLS (NUM_COLS),
		.NUM_ROWS (NUM_ROWS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.op            (op),
		.char_code     (char_code),
		.read_row      (read_row),
		.read_col      (read_col),
		.cell_data     (cell_data),
		.cursor_column (cursor_column),
		.cursor_line   (cursor_line),
		.scrolled      (scrolled)
	);

endmodule
